// File: hw/rtl/lrx_pkg.sv
`timescale 1ns / 1ps
// Shared widths, request and component codes for the lidar point projection block.
package lrx_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLUMNS = 2048;
    localparam int TABLE_DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam int REQ_W     = 2;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 11;
    localparam int COMP_W    = 3;
    localparam int TVAL_W    = 37;
    localparam int SHIFT_W   = 12;
    localparam int RANGE_W   = 20;
    localparam int CHAN_W    = 16;
    localparam int TIME_W    = 64;
    localparam int DIR_W     = 32;
    localparam int OFS_W     = 37;
    localparam int COORD_W   = 38;
    localparam int REL_W     = 32;
    localparam int WIDTH_W   = 12;
    localparam int NUM_AXES  = 3;

    localparam int S_TDATA_W = 272;
    localparam int S_TUSER_W = REQ_W;
    localparam int M_TDATA_W = 232;

    // rounding of the Q1.30 product down to 16 fractional bits
    localparam int FRAC_DROP = 14;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = WIDTH_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_DESTAGGER_EN = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLUMNS      = 1'd1;

    localparam logic [WIDTH_W-1:0] COLUMNS_RESET = 12'd1024;

    localparam logic [REQ_W-1:0] REQ_TABLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SHIFT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd2;

    localparam logic [COMP_W-1:0] COMP_DIR_X = 3'd0;
    localparam logic [COMP_W-1:0] COMP_OFS_X = 3'd3;

endpackage

// File: hw/rtl/lrx_coord.sv
`timescale 1ns / 1ps
// One coordinate lane: range times direction, rounded, plus offset, saturated.
module lrx_coord (
    input  logic                                aclk,
    input  logic                                pipe_en,
    input  logic [lrx_pkg::RANGE_W-1:0]         range_i,
    input  logic signed [lrx_pkg::DIR_W-1:0]    dir_i,
    input  logic signed [lrx_pkg::OFS_W-1:0]    ofs_i,
    output logic signed [lrx_pkg::COORD_W-1:0]  coord_o
);
    import lrx_pkg::*;

    localparam int PROD_W = RANGE_W + 1 + DIR_W;
    localparam int RND_W  = PROD_W - FRAC_DROP;
    localparam int SUM_W  = RND_W + 1;

    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) <<< (FRAC_DROP - 1);
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [OFS_W-1:0]   ofs_d1_reg;
    logic signed [OFS_W-1:0]   ofs_d2_reg;
    logic signed [RND_W-1:0]   rnd_reg;
    logic signed [RND_W-1:0]   rnd_next;
    logic signed [PROD_W-1:0]  prod_biased;
    logic signed [SUM_W-1:0]   sum;
    logic signed [COORD_W-1:0] coord_next;
    logic signed [COORD_W-1:0] coord_reg;

    always_comb begin
        prod_biased = prod_reg + HALF_LSB;
        rnd_next    = prod_biased[PROD_W-1:FRAC_DROP];
    end

    always_comb begin
        sum = SUM_W'(rnd_reg) + SUM_W'(ofs_d2_reg);
        // clamp to the coordinate range when the top bits disagree
        if (sum[SUM_W-1:COORD_W-1] == '0 || sum[SUM_W-1:COORD_W-1] == '1) begin
            coord_next = sum[COORD_W-1:0];
        end else if (sum[SUM_W-1]) begin
            coord_next = COORD_MIN;
        end else begin
            coord_next = COORD_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            prod_reg   <= $signed({1'b0, range_i}) * dir_i;
            ofs_d1_reg <= ofs_i;
            rnd_reg    <= rnd_next;
            ofs_d2_reg <= ofs_d1_reg;
            coord_reg  <= coord_next;
        end
    end

    assign coord_o = coord_reg;

endmodule

// File: hw/rtl/lidar_range_to_xyz_point.sv
`timescale 1ns / 1ps
// Lidar pixel projection top level: tables, destagger wrap, time and output skid.
// A pixel word passes stage registers p1 to p5 and the output register before m_axis.
// Throughput: one word per cycle while the skid is empty; the five-stage pipeline sets it.
// Reset clears pipeline valid bits, row-shift valid bits and configuration; lookup tables
// keep no reset and hold whatever was loaded.
module lidar_range_to_xyz_point (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lrx_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [lrx_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // row, column, component, table_value, row_shift, range_count, signal_level,
    // reflectivity_level, ambient_level, column_time, reference_time, zero fill
    input  logic [lrx_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // req_type
    input  logic [lrx_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // ring, target_column, x_coord, y_coord, z_coord, range_out, signal_out,
    // reflectivity_out, ambient_out, relative_time, zero fill
    output logic [lrx_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // point_valid
    output logic                              m_axis_tuser
);
    import lrx_pkg::*;

    localparam int STEP_BITS = WIDTH_W / 2;

    typedef struct packed {
        logic [S_TDATA_W-265-1:0]  pad;
        logic [TIME_W-1:0]         ref_time;
        logic [TIME_W-1:0]         col_time;
        logic [CHAN_W-1:0]         amb;
        logic [CHAN_W-1:0]         refl;
        logic [CHAN_W-1:0]         sig;
        logic [RANGE_W-1:0]        rng;
        logic [SHIFT_W-1:0]        shift;
        logic [TVAL_W-1:0]         tval;
        logic [COMP_W-1:0]         comp;
        logic [COL_W-1:0]          col;
        logic [ROW_W-1:0]          row;
    } s_word_t;

    typedef struct packed {
        logic [M_TDATA_W-231-1:0]  pad;
        logic [REL_W-1:0]          rel;
        logic [CHAN_W-1:0]         amb;
        logic [CHAN_W-1:0]         refl;
        logic [CHAN_W-1:0]         sig;
        logic [RANGE_W-1:0]        rng;
        logic [COORD_W-1:0]        z;
        logic [COORD_W-1:0]        y;
        logic [COORD_W-1:0]        x;
        logic [COL_W-1:0]          target;
        logic [ROW_W-1:0]          ring;
    } m_word_t;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [RANGE_W-1:0]  rng;
        logic [CHAN_W-1:0]   sig;
        logic [CHAN_W-1:0]   refl;
        logic [CHAN_W-1:0]   amb;
    } pix_t;

    function automatic logic [WIDTH_W-1:0] rem_steps(
        input logic [WIDTH_W-1:0]   rem_in,
        input logic [STEP_BITS-1:0] bits,
        input logic [WIDTH_W-1:0]   divisor
    );
        logic [WIDTH_W:0]   part;
        logic [WIDTH_W-1:0] rem;
        rem = rem_in;
        for (int i = STEP_BITS - 1; i >= 0; i--) begin
            part = {rem, bits[i]};
            if (part >= {1'b0, divisor}) begin
                part = part - {1'b0, divisor};
            end
            rem = part[WIDTH_W-1:0];
        end
        return rem;
    endfunction

    s_word_t in_word;
    logic    pipe_en;
    logic    s_accept;
    logic    table_we;
    logic    shift_we;
    logic    pixel_in;
    logic [ADDR_W-1:0] tab_addr;
    logic [NUM_AXES-1:0] dir_we;
    logic [NUM_AXES-1:0] ofs_we;
    logic signed [DIR_W-1:0] dir_wr_val;

    // configuration
    logic               destag_en_reg;
    logic [WIDTH_W-1:0] columns_reg;
    logic               destag_on;

    // row shift store
    logic [SHIFT_W-1:0] shift_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] shift_vld_reg;
    logic [SHIFT_W-1:0] shift_rd_reg;
    logic               shift_vld_rd_reg;

    // table read data
    logic signed [DIR_W-1:0]   dir_rd_reg [NUM_AXES];
    logic signed [OFS_W-1:0]   ofs_rd_reg [NUM_AXES];
    logic signed [COORD_W-1:0] coord_val  [NUM_AXES];

    // pipeline
    logic               p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg, p5_valid_reg;
    pix_t               p1_pix_reg, p2_pix_reg, p3_pix_reg, p4_pix_reg, p5_pix_reg;
    logic [TIME_W-1:0]  p1_ct_reg, p1_rt_reg;
    logic [REL_W-1:0]   p2_rel_reg, p3_rel_reg, p4_rel_reg, p5_rel_reg;
    logic               p2_neg_reg, p3_neg_reg, p4_neg_reg;
    logic [WIDTH_W-1:0] p2_mag_reg;
    logic [WIDTH_W-1:0] p3_rem_reg, p4_rem_reg;
    logic [STEP_BITS-1:0] p3_low_reg;
    logic [COL_W-1:0]   p5_target_reg;
    logic [COORD_W-1:0] p5_coord_reg [NUM_AXES];

    logic [REL_W-1:0]   rel_next;
    logic [TIME_W:0]    time_diff;
    logic [SHIFT_W-1:0] shift_eff;
    logic signed [WIDTH_W:0] wrap_sum;
    logic [WIDTH_W:0]   wrap_mag;
    logic [WIDTH_W-1:0] wrapped;
    logic [COL_W-1:0]   target_next;

    // output skid
    m_word_t p5_word;
    m_word_t out_word_reg, skid_word_reg, out_word_view;
    logic    out_user_reg, skid_user_reg;
    logic    out_valid_reg, skid_full_reg;
    logic    push;

    assign in_word       = s_word_t'(s_axis_tdata);
    assign pipe_en       = !skid_full_reg;
    assign s_axis_tready = pipe_en;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign tab_addr      = {in_word.row, in_word.col};
    assign destag_on     = destag_en_reg && (columns_reg != '0);

    always_comb begin
        table_we = 1'b0;
        shift_we = 1'b0;
        pixel_in = 1'b0;
        unique case (s_axis_tuser)
            REQ_TABLE: table_we = s_accept;
            REQ_SHIFT: shift_we = s_accept;
            REQ_PIXEL: pixel_in = s_accept;
            default: ;
        endcase
        for (int a = 0; a < NUM_AXES; a++) begin
            dir_we[a] = table_we && (in_word.comp == COMP_W'(COMP_DIR_X + COMP_W'(a)));
            ofs_we[a] = table_we && (in_word.comp == COMP_W'(COMP_OFS_X + COMP_W'(a)));
        end
        // clamp direction loads to the 32-bit store
        if (in_word.tval[TVAL_W-1:DIR_W-1] == '0 || in_word.tval[TVAL_W-1:DIR_W-1] == '1) begin
            dir_wr_val = in_word.tval[DIR_W-1:0];
        end else if (in_word.tval[TVAL_W-1]) begin
            dir_wr_val = {1'b1, {(DIR_W-1){1'b0}}};
        end else begin
            dir_wr_val = {1'b0, {(DIR_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            destag_en_reg <= 1'b0;
            columns_reg   <= COLUMNS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_DESTAGGER_EN: destag_en_reg <= cfg_wdata[0];
                CFG_COLUMNS:      columns_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_vld_reg <= '0;
        end else if (shift_we) begin
            shift_vld_reg[in_word.row] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_we) begin
            shift_mem[in_word.row] <= in_word.shift;
        end
        if (pipe_en) begin
            shift_rd_reg     <= shift_mem[in_word.row];
            shift_vld_rd_reg <= shift_vld_reg[in_word.row];
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_AXES; g++) begin : g_axis
            logic [DIR_W-1:0] dir_mem [TABLE_DEPTH];
            logic [OFS_W-1:0] ofs_mem [TABLE_DEPTH];

            always_ff @(posedge aclk) begin
                if (dir_we[g]) begin
                    dir_mem[tab_addr] <= dir_wr_val;
                end
                if (pipe_en) begin
                    dir_rd_reg[g] <= dir_mem[tab_addr];
                end
            end

            always_ff @(posedge aclk) begin
                if (ofs_we[g]) begin
                    ofs_mem[tab_addr] <= in_word.tval;
                end
                if (pipe_en) begin
                    ofs_rd_reg[g] <= ofs_mem[tab_addr];
                end
            end

            lrx_coord u_coord (
                .aclk    (aclk),
                .pipe_en (pipe_en),
                .range_i (p1_pix_reg.rng),
                .dir_i   (dir_rd_reg[g]),
                .ofs_i   (ofs_rd_reg[g]),
                .coord_o (coord_val[g])
            );
        end
    endgenerate

    // stage 2: relative time and signed destagger sum
    always_comb begin
        time_diff = {1'b0, p1_ct_reg} - {1'b0, p1_rt_reg};
        if (time_diff[TIME_W]) begin
            rel_next = '0;
        end else if (time_diff[TIME_W-1:REL_W] != '0) begin
            rel_next = '1;
        end else begin
            rel_next = time_diff[REL_W-1:0];
        end
        shift_eff = shift_vld_rd_reg ? shift_rd_reg : '0;
        wrap_sum  = $signed({2'b00, p1_pix_reg.col}) + $signed({shift_eff[SHIFT_W-1], shift_eff});
        wrap_mag  = wrap_sum[WIDTH_W] ? (WIDTH_W+1)'(-wrap_sum) : wrap_sum;
    end

    // stage 5: fold a negative remainder back into range
    always_comb begin
        if (p4_neg_reg && p4_rem_reg != '0) begin
            wrapped = columns_reg - p4_rem_reg;
        end else begin
            wrapped = p4_rem_reg;
        end
        target_next = destag_on ? wrapped[COL_W-1:0] : p4_pix_reg.col;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            p1_valid_reg <= pixel_in;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p1_pix_reg <= '{row: in_word.row, col: in_word.col, rng: in_word.rng,
                            sig: in_word.sig, refl: in_word.refl, amb: in_word.amb};
            p1_ct_reg  <= in_word.col_time;
            p1_rt_reg  <= in_word.ref_time;

            p2_pix_reg <= p1_pix_reg;
            p2_rel_reg <= rel_next;
            p2_neg_reg <= wrap_sum[WIDTH_W];
            p2_mag_reg <= wrap_mag[WIDTH_W-1:0];

            p3_pix_reg <= p2_pix_reg;
            p3_rel_reg <= p2_rel_reg;
            p3_neg_reg <= p2_neg_reg;
            p3_rem_reg <= rem_steps('0, p2_mag_reg[WIDTH_W-1:STEP_BITS], columns_reg);
            p3_low_reg <= p2_mag_reg[STEP_BITS-1:0];

            p4_pix_reg <= p3_pix_reg;
            p4_rel_reg <= p3_rel_reg;
            p4_neg_reg <= p3_neg_reg;
            p4_rem_reg <= rem_steps(p3_rem_reg, p3_low_reg, columns_reg);

            p5_pix_reg    <= p4_pix_reg;
            p5_rel_reg    <= p4_rel_reg;
            p5_target_reg <= target_next;
            for (int a = 0; a < NUM_AXES; a++) begin
                // no return: drop the coordinates to zero
                p5_coord_reg[a] <= (p4_pix_reg.rng == '0) ? '0 : coord_val[a];
            end
        end
    end

    always_comb begin
        p5_word        = '0;
        p5_word.ring   = p5_pix_reg.row;
        p5_word.target = p5_target_reg;
        p5_word.x      = p5_coord_reg[0];
        p5_word.y      = p5_coord_reg[1];
        p5_word.z      = p5_coord_reg[2];
        p5_word.rng    = p5_pix_reg.rng;
        p5_word.sig    = p5_pix_reg.sig;
        p5_word.refl   = p5_pix_reg.refl;
        p5_word.amb    = p5_pix_reg.amb;
        p5_word.rel    = p5_rel_reg;
    end

    assign push = pipe_en && p5_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_axis_tready) begin
                skid_full_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || m_axis_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_full_reg <= 1'b1;
            end
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_full_reg) begin
            if (m_axis_tready) begin
                out_word_reg <= skid_word_reg;
                out_user_reg <= skid_user_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || m_axis_tready) begin
                out_word_reg <= p5_word;
                out_user_reg <= (p5_pix_reg.rng != '0);
            end else begin
                // park the word while the consumer holds off
                skid_word_reg <= p5_word;
                skid_user_reg <= (p5_pix_reg.rng != '0);
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_word_reg;
    assign m_axis_tuser  = out_user_reg;
    assign out_word_view = m_word_t'(m_axis_tdata);

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> out_valid_reg)
        else $error("skid holds a word while the output register is empty");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_axis_tuser != REQ_PIXEL) |=> !p1_valid_reg)
        else $error("load word entered the point pipeline");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> ($stable(p5_valid_reg) && $stable(p4_valid_reg)))
        else $error("pipeline moved during a stall");

    a_no_return_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |->
        (out_word_view.x == '0 && out_word_view.y == '0 && out_word_view.z == '0
         && out_word_view.rng == '0))
        else $error("invalid point carries nonzero coordinates");

endmodule

// File: tb/lidar_range_to_xyz_point_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the lidar range-to-point projection block.
module lidar_range_to_xyz_point_tb;
    import lrx_pkg::*;

    localparam logic [REQ_W-1:0]  REQ_IGNORED   = 2'd3;
    localparam logic [COMP_W-1:0] COMP_DIR_Y    = COMP_DIR_X + 3'd1;
    localparam logic [COMP_W-1:0] COMP_DIR_Z    = COMP_DIR_X + 3'd2;
    localparam logic [COMP_W-1:0] COMP_OFS_Y    = COMP_OFS_X + 3'd1;
    localparam logic [COMP_W-1:0] COMP_OFS_Z    = COMP_OFS_X + 3'd2;
    localparam logic [COMP_W-1:0] COMP_SPARE_LO = 3'd6;
    localparam logic [COMP_W-1:0] COMP_SPARE_HI = 3'd7;
    localparam int NUM_COMPS = 2 * NUM_AXES;

    localparam longint COORD_HI = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;
    localparam longint DIR_HI   = (longint'(1) <<< (DIR_W - 1)) - 1;
    localparam longint DIR_LO   = -DIR_HI - 1;

    localparam int LATENCY_PAUSE = 10;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic [REQ_W-1:0]   kind;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [COMP_W-1:0]  comp;
        logic [TVAL_W-1:0]  tval;
        logic [SHIFT_W-1:0] shift;
        logic [RANGE_W-1:0] rng;
        logic [CHAN_W-1:0]  sig;
        logic [CHAN_W-1:0]  refl;
        logic [CHAN_W-1:0]  amb;
        logic [TIME_W-1:0]  col_time;
        logic [TIME_W-1:0]  ref_time;
    } lidar_word_t;

    typedef struct {
        logic [ROW_W-1:0]   ring;
        logic [COL_W-1:0]   tcol;
        logic               pv;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [RANGE_W-1:0] rng;
        logic [CHAN_W-1:0]  sig;
        logic [CHAN_W-1:0]  refl;
        logic [CHAN_W-1:0]  amb;
        logic [REL_W-1:0]   rel;
    } point_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;

    // shadow of the block's tables and registers
    longint                    entry_tab [int];
    bit                        entry_full [int];
    int                        ready_entries [$];
    logic signed [SHIFT_W-1:0] shift_tab [MAX_ROWS] = '{default: '0};
    logic                      stagger_on = 1'b0;
    int                        frame_cols = int'(COLUMNS_RESET);

    point_t pending_points [$];
    point_t seen_point;
    point_t want_point;

    bit steady = 1'b0;
    int cycle_count    = 0;
    int mismatch_count = 0;
    int points_checked = 0;
    int pixels_sent    = 0;
    int loads_sent     = 0;
    int settings_used  = 0;

    lidar_range_to_xyz_point DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 33);
    end

    function automatic logic [S_TDATA_W-1:0] pack_word(lidar_word_t w);
        // seven bits of zero fill on top
        return {7'd0, w.ref_time, w.col_time, w.amb, w.refl, w.sig, w.rng, w.shift, w.tval,
                w.comp, w.col, w.row};
    endfunction

    function automatic point_t unpack_point(logic [M_TDATA_W-1:0] d, logic pv);
        point_t p;
        logic   fill;
        {fill, p.rel, p.amb, p.refl, p.sig, p.rng, p.z, p.y, p.x, p.tcol, p.ring} = d;
        p.pv = pv;
        return p;
    endfunction

    function automatic lidar_word_t random_word();
        lidar_word_t w;
        w.kind     = REQ_W'($urandom);
        w.row      = ROW_W'($urandom);
        w.col      = COL_W'($urandom);
        w.comp     = COMP_W'($urandom);
        w.tval     = TVAL_W'({$urandom, $urandom});
        w.shift    = SHIFT_W'($urandom);
        w.rng      = RANGE_W'($urandom);
        w.sig      = CHAN_W'($urandom);
        w.refl     = CHAN_W'($urandom);
        w.amb      = CHAN_W'($urandom);
        w.col_time = {$urandom, $urandom};
        w.ref_time = {$urandom, $urandom};
        return w;
    endfunction

    function automatic longint entry_value(logic [COMP_W-1:0] comp, int idx);
        int key;
        key = int'(comp) * TABLE_DEPTH + idx;
        return entry_tab.exists(key) ? entry_tab[key] : 0;
    endfunction

    function automatic logic [COORD_W-1:0] project_axis(logic [RANGE_W-1:0] rng, longint dir,
                                                        longint ofs);
        longint r;
        longint c;
        r = longint'(rng);
        // round half toward plus infinity, then add the offset and clamp
        c = ((r * dir + (longint'(1) <<< (FRAC_DROP - 1))) >>> FRAC_DROP) + ofs;
        if (c > COORD_HI) c = COORD_HI;
        else if (c < COORD_LO) c = COORD_LO;
        return c[COORD_W-1:0];
    endfunction

    // Update the shadow state for one accepted word and queue the point it yields.
    function automatic void apply_word(lidar_word_t w);
        int                idx;
        int                s;
        bit                full;
        longint            v;
        logic [TIME_W-1:0] diff;
        point_t            p;
        idx = int'({w.row, w.col});
        case (w.kind)
            REQ_TABLE: begin
                v = longint'({{(64 - TVAL_W){w.tval[TVAL_W-1]}}, w.tval});
                if (w.comp <= COMP_DIR_Z) begin
                    if (v > DIR_HI) v = DIR_HI;
                    else if (v < DIR_LO) v = DIR_LO;
                end
                if (w.comp <= COMP_OFS_Z) begin
                    entry_tab[int'(w.comp) * TABLE_DEPTH + idx] = v;
                    if (!entry_full.exists(idx)) begin
                        full = 1'b1;
                        for (int c = 0; c < NUM_COMPS; c++)
                            if (!entry_tab.exists(c * TABLE_DEPTH + idx)) full = 1'b0;
                        if (full) begin
                            entry_full[idx] = 1'b1;
                            ready_entries.insert(ready_entries.size(), idx);
                        end
                    end
                end
            end
            REQ_SHIFT: begin
                shift_tab[w.row] = w.shift;
            end
            REQ_PIXEL: begin
                p.ring = w.row;
                p.tcol = w.col;
                if (stagger_on && frame_cols != 0) begin
                    s = (int'(w.col) + int'(shift_tab[w.row])) % frame_cols;
                    if (s < 0) s += frame_cols;
                    p.tcol = s[COL_W-1:0];
                end
                if (w.col_time >= w.ref_time) begin
                    diff  = w.col_time - w.ref_time;
                    p.rel = (diff > 64'hFFFF_FFFF) ? '1 : diff[REL_W-1:0];
                end else begin
                    p.rel = '0;
                end
                if (w.rng == '0) begin
                    p.pv = 1'b0;
                    p.x  = '0;
                    p.y  = '0;
                    p.z  = '0;
                end else begin
                    p.pv = 1'b1;
                    p.x  = project_axis(w.rng, entry_value(COMP_DIR_X, idx),
                                        entry_value(COMP_OFS_X, idx));
                    p.y  = project_axis(w.rng, entry_value(COMP_DIR_Y, idx),
                                        entry_value(COMP_OFS_Y, idx));
                    p.z  = project_axis(w.rng, entry_value(COMP_DIR_Z, idx),
                                        entry_value(COMP_OFS_Z, idx));
                end
                p.rng  = w.rng;
                p.sig  = w.sig;
                p.refl = w.refl;
                p.amb  = w.amb;
                pending_points.insert(pending_points.size(), p);
            end
            default: ;
        endcase
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            seen_point = unpack_point(m_axis_tdata, m_axis_tuser);
            if (pending_points.size() == 0) begin
                $error("point word with no pixel waiting for it");
                mismatch_count++;
            end else begin
                want_point = pending_points.pop_front();
                check_field("ring", want_point.ring, seen_point.ring);
                check_field("target_column", want_point.tcol, seen_point.tcol);
                check_field("point_valid", want_point.pv, seen_point.pv);
                check_field("x_coord", want_point.x, seen_point.x);
                check_field("y_coord", want_point.y, seen_point.y);
                check_field("z_coord", want_point.z, seen_point.z);
                check_field("range_out", want_point.rng, seen_point.rng);
                check_field("signal_out", want_point.sig, seen_point.sig);
                check_field("reflectivity_out", want_point.refl, seen_point.refl);
                check_field("ambient_out", want_point.amb, seen_point.amb);
                check_field("relative_time", want_point.rel, seen_point.rel);
                points_checked++;
            end
        end
    end

    // Called just after a rising edge; leaves tvalid high for a following word.
    task automatic send_word(lidar_word_t w);
        while (!steady && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.kind;
        s_axis_tdata  <= pack_word(w);
        do @(posedge aclk); while (!s_axis_tready);
        apply_word(w);
        if (w.kind == REQ_PIXEL) pixels_sent++;
        else loads_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        // loads leave no trace on the output; let them clear the pipeline
        repeat (LATENCY_PAUSE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (addr == CFG_DESTAGGER_EN) stagger_on = value[0];
        else frame_cols = int'(value);
    endtask

    task automatic apply_setting(bit enable, int cols);
        write_reg(CFG_DESTAGGER_EN, CFG_DATA_W'(enable));
        write_reg(CFG_COLUMNS, CFG_DATA_W'(cols));
    endtask

    task automatic load_word(int row, int col, logic [COMP_W-1:0] comp,
                             logic [TVAL_W-1:0] value);
        lidar_word_t w;
        w      = random_word();
        w.kind = REQ_TABLE;
        w.row  = ROW_W'(row);
        w.col  = COL_W'(col);
        w.comp = comp;
        w.tval = value;
        send_word(w);
    endtask

    task automatic shift_word(int row, int shift);
        lidar_word_t w;
        w       = random_word();
        w.kind  = REQ_SHIFT;
        w.row   = ROW_W'(row);
        w.shift = SHIFT_W'(shift);
        send_word(w);
    endtask

    task automatic pixel_word(int row, int col, logic [RANGE_W-1:0] rng,
                              logic [CHAN_W-1:0] chan, logic [TIME_W-1:0] ct,
                              logic [TIME_W-1:0] rt);
        lidar_word_t w;
        w          = random_word();
        w.kind     = REQ_PIXEL;
        w.row      = ROW_W'(row);
        w.col      = COL_W'(col);
        w.rng      = rng;
        w.sig      = chan;
        w.refl     = ~chan;
        w.amb      = chan;
        w.col_time = ct;
        w.ref_time = rt;
        send_word(w);
    endtask

    function automatic logic [TVAL_W-1:0] random_table_value(logic [COMP_W-1:0] comp);
        longint v;
        if ($urandom_range(99) < 20) return TVAL_W'({$urandom, $urandom});
        // mostly unit-scale directions and modest offsets
        if (comp <= COMP_DIR_Z) v = longint'($urandom_range(32'h8000_0000)) - (longint'(1) <<< 30);
        else v = longint'($urandom_range(32'h0200_0000)) - (longint'(1) <<< 24);
        return v[TVAL_W-1:0];
    endfunction

    task automatic build_entry();
        int row;
        int col;
        int start;
        logic [COMP_W-1:0] comp;
        row   = $urandom_range(MAX_ROWS - 1);
        col   = $urandom_range(MAX_COLUMNS - 1);
        start = $urandom_range(NUM_COMPS - 1);
        for (int i = 0; i < NUM_COMPS; i++) begin
            comp = COMP_W'((start + i) % NUM_COMPS);
            load_word(row, col, comp, random_table_value(comp));
        end
    endtask

    task automatic send_random_items(int count);
        lidar_word_t w;
        int pick;
        int n;
        int k;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(99);
            if (ready_entries.size() == 0 || pick < 10) begin
                build_entry();
                n += NUM_COMPS;
            end else if (pick < 18) begin
                shift_word($urandom_range(MAX_ROWS - 1), int'($urandom_range(4094)) - 2047);
                n++;
            end else if (pick < 23) begin
                w = random_word();
                case ($urandom_range(2))
                    0: w.kind = REQ_IGNORED;
                    1: begin
                        w.kind = REQ_TABLE;
                        w.comp = $urandom_range(1) ? COMP_SPARE_HI : COMP_SPARE_LO;
                    end
                    default: begin
                        // overwrite one component of an entry already in use
                        k      = ready_entries[$urandom_range(ready_entries.size() - 1)];
                        w.kind = REQ_TABLE;
                        w.row  = k[COL_W +: ROW_W];
                        w.col  = k[COL_W-1:0];
                        w.comp = COMP_W'($urandom_range(NUM_COMPS - 1));
                        w.tval = random_table_value(w.comp);
                    end
                endcase
                send_word(w);
                n++;
            end else begin
                w      = random_word();
                w.kind = REQ_PIXEL;
                k      = ready_entries[$urandom_range(ready_entries.size() - 1)];
                w.row  = k[COL_W +: ROW_W];
                w.col  = k[COL_W-1:0];
                case ($urandom_range(9))
                    0: w.rng = '0;
                    1: w.rng = '1;
                    2, 3, 4: w.rng = RANGE_W'($urandom_range(4095));
                    default: ;
                endcase
                if ($urandom_range(19) == 0) w.sig = '0;
                case ($urandom_range(4))
                    1: w.col_time = w.ref_time + $urandom;
                    2: w.col_time = w.ref_time + {31'd0, 1'($urandom), $urandom};
                    3: w.col_time = w.ref_time - $urandom_range(100000);
                    4: w.col_time = w.ref_time;
                    default: ;
                endcase
                send_word(w);
                n++;
            end
        end
    endtask

    task automatic test_load_and_project();
        lidar_word_t w;
        logic [TIME_W-1:0] rt;
        // directions too wide for 32 bits clamp on the way in
        load_word(0, 0, COMP_DIR_X, {1'b0, {(TVAL_W - 1){1'b1}}});
        load_word(0, 0, COMP_DIR_Y, {1'b1, {(TVAL_W - 1){1'b0}}});
        load_word(0, 0, COMP_DIR_Z, TVAL_W'(longint'(1) <<< 30));
        load_word(0, 0, COMP_OFS_X, {1'b0, {(TVAL_W - 1){1'b1}}});
        load_word(0, 0, COMP_OFS_Y, {1'b1, {(TVAL_W - 1){1'b0}}});
        load_word(0, 0, COMP_OFS_Z, '0);
        // products landing exactly on a half
        load_word(MAX_ROWS - 1, MAX_COLUMNS - 1, COMP_DIR_X, 37'sd8192);
        load_word(MAX_ROWS - 1, MAX_COLUMNS - 1, COMP_DIR_Y, -37'sd8192);
        load_word(MAX_ROWS - 1, MAX_COLUMNS - 1, COMP_DIR_Z, -37'sd8193);
        load_word(MAX_ROWS - 1, MAX_COLUMNS - 1, COMP_OFS_X, '0);
        load_word(MAX_ROWS - 1, MAX_COLUMNS - 1, COMP_OFS_Y, 37'sd1);
        load_word(MAX_ROWS - 1, MAX_COLUMNS - 1, COMP_OFS_Z, '1);
        // spare component codes and the unused request type must leave tables alone
        load_word(0, 0, COMP_SPARE_LO, '1);
        load_word(0, 0, COMP_SPARE_HI, TVAL_W'({$urandom, $urandom}));
        w      = random_word();
        w.kind = REQ_IGNORED;
        send_word(w);
        shift_word(MAX_ROWS - 1, -2047);
        shift_word(0, 2047);
        rt = {$urandom, $urandom};
        // full range drives the x and y axes into the clamp; time saturates
        pixel_word(0, 0, '1, '1, '1, '0);
        // no return: zero point, earlier column time
        pixel_word(0, 0, '0, '0, '0, 64'd1);
        pixel_word(MAX_ROWS - 1, MAX_COLUMNS - 1, 20'd1, 16'h5A5A, rt, rt);
        pixel_word(MAX_ROWS - 1, MAX_COLUMNS - 1, 20'd2, 16'hA5A5, rt + 64'd5, rt);
        pixel_word(0, 0, 20'd1, 16'h00FF, rt + 64'h1_0000_0000, rt);
    endtask

    task automatic test_destagger_settings();
        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            case (phase)
                0: write_reg(CFG_DESTAGGER_EN, CFG_DATA_W'(1));
                1: apply_setting(1'b1, 1);
                2: apply_setting(1'b1, 2);
                3: apply_setting(1'b1, MAX_COLUMNS);
                4: apply_setting(1'b1, (1 << WIDTH_W) - 1);
                5: apply_setting(1'b1, 0);
                6: apply_setting(1'b1, $urandom_range(3, MAX_COLUMNS - 1));
                default: apply_setting(1'b0, MAX_COLUMNS);
            endcase
            settings_used++;
            send_random_items(60);
        end
    endtask

    task automatic test_random_stream();
        int cols;
        for (int chunk = 0; chunk < 10; chunk++) begin
            wait_drained();
            cols = ($urandom_range(3) == 0) ? int'(CFG_DATA_W'($urandom))
                                            : int'($urandom_range(1, MAX_COLUMNS));
            apply_setting(1'($urandom), cols);
            settings_used++;
            // one stretch with neither side holding off
            steady <= (chunk == 4);
            send_random_items(140);
        end
        steady <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_load_and_project();
        test_destagger_settings();
        test_random_stream();
        wait_drained();
        $display("Projected %0d pixel words around %0d table, shift and ignored words,",
                 pixels_sent, loads_sent);
        $display("over %0d destagger settings; %0d points checked, %0d mismatches.",
                 settings_used, points_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
